[hw/rtl/icgc_pkg.sv]
package icgc_pkg;

  localparam int unsigned SPACE_OBJS_DEF = 256;
  localparam int unsigned PAGE_OBJS_DEF  = 64;
  localparam int unsigned VALUE_BITS_DEF = 32;

  localparam int unsigned MODE_BITS   = 3;
  localparam int unsigned STATUS_BITS = 2;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_ALLOC    = 3'd0,
    MODE_RD_VALUE = 3'd1,
    MODE_WR_VALUE = 3'd2,
    MODE_RD_LINK  = 3'd3,
    MODE_WR_LINK  = 3'd4,
    MODE_RD_ROOT  = 3'd5,
    MODE_WR_ROOT  = 3'd6
  } mode_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_OOS  = 2'd1,
    STATUS_NULL = 2'd2
  } status_t;

endpackage

[hw/rtl/icgc_store.sv]
module icgc_store #(
  parameter int unsigned DEPTH = 2 * icgc_pkg::SPACE_OBJS_DEF,
  parameter int unsigned WIDTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/icgc_engine.sv]
module icgc_engine #(
  parameter int unsigned SPACE_OBJS = icgc_pkg::SPACE_OBJS_DEF,
  parameter int unsigned PAGE_OBJS  = icgc_pkg::PAGE_OBJS_DEF,
  parameter int unsigned VALUE_BITS = icgc_pkg::VALUE_BITS_DEF,
  localparam int unsigned NOBJ = 2 * SPACE_OBJS,
  localparam int unsigned AW   = $clog2(NOBJ),
  localparam int unsigned HW   = AW + 1,
  localparam int unsigned WW   = 1 + AW + HW + VALUE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [icgc_pkg::MODE_BITS-1:0]    in_mode,
  input  logic [HW-1:0]                     in_handle,
  input  logic                              in_sel,
  input  logic [VALUE_BITS-1:0]             in_wval,
  input  logic [HW-1:0]                     in_wptr,
  input  logic                              res_free,
  output logic                              res_valid,
  output logic [HW-1:0]                     res_handle,
  output logic [VALUE_BITS-1:0]             res_value,
  output logic [HW-1:0]                     res_ptr,
  output logic [icgc_pkg::STATUS_BITS-1:0]  res_status,
  output logic                              mem_we,
  output logic [AW-1:0]                     mem_waddr,
  output logic [WW-1:0]                     mem_wdata,
  output logic                              mem_re,
  output logic [AW-1:0]                     mem_raddr,
  input  logic [WW-1:0]                     mem_rdata
);

  localparam int unsigned SW = $clog2(SPACE_OBJS);
  localparam int unsigned PW = $clog2(PAGE_OBJS + 1);
  localparam logic [HW-1:0] NULL_H = HW'(NOBJ);
  localparam logic [AW-1:0] SPACE_A = AW'(SPACE_OBJS);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_FWD, ST_FWD_W, ST_FWD_CHK, ST_FWD_MARK,
    ST_RET, ST_ACC_W, ST_ACC_DO, ST_SCAN, ST_SCAN_W, ST_SCAN_GOT,
    ST_ALLOC_FLIP, ST_ALLOC_TAKE, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    CL_ACC, CL_ROOT, CL_FLIP1, CL_FLIP2, CL_SCAN
  } caller_t;

  state_t              state;
  caller_t             caller;
  icgc_pkg::mode_t     mode_r;
  icgc_pkg::status_t   status_r;
  logic [HW-1:0]       hin_r;
  logic                sel_r;
  logic [VALUE_BITS-1:0] wval_r;
  logic [HW-1:0]       wptr_r;
  logic [HW-1:0]       fh;
  logic [HW-1:0]       fres;
  logic [WW-1:0]       word;
  logic [WW-1:0]       scan_word;
  logic [AW-1:0]       nslot;
  logic                oos;
  logic                to_half;
  logic [SW-1:0]       free_ptr;
  logic [SW-1:0]       scan_ptr;
  logic                collecting;
  logic [HW-1:0]       head_root;
  logic [HW-1:0]       tail_root;
  logic [PW-1:0]       page_cnt;
  logic [AW-1:0]       clr_addr;
  logic [AW-1:0]       clr_last;
  logic                clr_boot;

  logic [AW-1:0]       to_base;
  logic [AW-1:0]       from_base;
  logic                fh_from;
  logic                slot_full;
  logic [AW-1:0]       new_slot;
  logic                rd_fv;
  logic [AW-1:0]       rd_fa;
  logic [HW-1:0]       rd_link;
  logic [VALUE_BITS-1:0] rd_val;
  logic [WW-1:0]       clear_word;
  logic [HW-1:0]       wptr_norm;

  assign to_base    = to_half ? SPACE_A : '0;
  assign from_base  = to_half ? '0 : SPACE_A;
  assign fh_from    = (fh < NULL_H) && ((fh >= HW'(SPACE_OBJS)) != to_half);
  assign slot_full  = ({1'b0, free_ptr} + (SW+1)'(1)) >= (SW+1)'(SPACE_OBJS);
  assign new_slot   = to_base + AW'(free_ptr);
  assign rd_val     = mem_rdata[VALUE_BITS-1:0];
  assign rd_link    = mem_rdata[VALUE_BITS +: HW];
  assign rd_fa      = mem_rdata[VALUE_BITS+HW +: AW];
  assign rd_fv      = mem_rdata[WW-1];
  assign clear_word = {1'b0, {AW{1'b0}}, NULL_H, {VALUE_BITS{1'b0}}};
  assign wptr_norm  = (wptr_r >= NULL_H) ? NULL_H : wptr_r;
  assign in_ready   = (state == ST_IDLE);
  assign res_status = status_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      caller     <= CL_ACC;
      to_half    <= 1'b1;
      free_ptr   <= '0;
      scan_ptr   <= '0;
      collecting <= 1'b0;
      head_root  <= NULL_H;
      tail_root  <= NULL_H;
      clr_addr   <= '0;
      clr_last   <= AW'(NOBJ - 1);
      clr_boot   <= 1'b1;
      oos        <= 1'b0;
      res_valid  <= 1'b0;
      mem_we     <= 1'b0;
      mem_re     <= 1'b0;
    end else begin
      mem_we    <= 1'b0;
      mem_re    <= 1'b0;
      res_valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          mem_we    <= 1'b1;
          mem_waddr <= clr_addr;
          mem_wdata <= clear_word;
          if (clr_addr == clr_last) begin
            state <= clr_boot ? ST_IDLE : ST_ALLOC_FLIP;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            mode_r     <= icgc_pkg::mode_t'(in_mode);
            hin_r      <= in_handle;
            sel_r      <= in_sel;
            wval_r     <= in_wval;
            wptr_r     <= in_wptr;
            oos        <= 1'b0;
            res_handle <= NULL_H;
            res_value  <= '0;
            res_ptr    <= NULL_H;
            status_r   <= icgc_pkg::STATUS_OK;
            state      <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          case (mode_r)
            icgc_pkg::MODE_ALLOC: begin
              if (collecting && scan_ptr < free_ptr) begin
                page_cnt <= PW'(PAGE_OBJS);
                state    <= ST_SCAN;
              end else begin
                state <= ST_ALLOC_FLIP;
              end
            end
            icgc_pkg::MODE_RD_VALUE, icgc_pkg::MODE_WR_VALUE,
            icgc_pkg::MODE_RD_LINK, icgc_pkg::MODE_WR_LINK: begin
              if (hin_r >= NULL_H) begin
                status_r <= icgc_pkg::STATUS_NULL;
                state    <= ST_DONE;
              end else begin
                fh     <= hin_r;
                caller <= CL_ACC;
                state  <= ST_FWD;
              end
            end
            icgc_pkg::MODE_RD_ROOT: begin
              fh     <= sel_r ? tail_root : head_root;
              caller <= CL_ROOT;
              state  <= ST_FWD;
            end
            icgc_pkg::MODE_WR_ROOT: begin
              if (sel_r) begin
                tail_root <= wptr_norm;
              end else begin
                head_root <= wptr_norm;
              end
              state <= ST_DONE;
            end
            default: state <= ST_DONE;
          endcase
        end
        // read barrier: copy a from-space object once, then follow its mark
        ST_FWD: begin
          if (!fh_from) begin
            fres  <= fh;
            state <= ST_RET;
          end else begin
            mem_re    <= 1'b1;
            mem_raddr <= fh[AW-1:0];
            state     <= ST_FWD_W;
          end
        end
        ST_FWD_W: state <= ST_FWD_CHK;
        ST_FWD_CHK: begin
          word <= mem_rdata;
          if (rd_fv) begin
            fres  <= {1'b0, rd_fa};
            state <= ST_RET;
          end else if (slot_full) begin
            oos   <= 1'b1;
            fres  <= fh;
            state <= ST_RET;
          end else begin
            nslot     <= new_slot;
            free_ptr  <= free_ptr + SW'(1);
            mem_we    <= 1'b1;
            mem_waddr <= new_slot;
            mem_wdata <= {1'b0, {AW{1'b0}}, rd_link, rd_val};
            state     <= ST_FWD_MARK;
          end
        end
        ST_FWD_MARK: begin
          mem_we    <= 1'b1;
          mem_waddr <= fh[AW-1:0];
          mem_wdata <= {1'b1, nslot, word[VALUE_BITS +: HW], word[VALUE_BITS-1:0]};
          fres      <= {1'b0, nslot};
          state     <= ST_RET;
        end
        ST_RET: begin
          case (caller)
            CL_ACC: begin
              res_handle <= fres;
              mem_re     <= 1'b1;
              mem_raddr  <= fres[AW-1:0];
              state      <= ST_ACC_W;
            end
            CL_ROOT: begin
              if (sel_r) begin
                tail_root <= fres;
              end else begin
                head_root <= fres;
              end
              res_ptr <= fres;
              state   <= ST_DONE;
            end
            CL_FLIP1: begin
              head_root <= fres;
              fh        <= tail_root;
              caller    <= CL_FLIP2;
              state     <= ST_FWD;
            end
            CL_FLIP2: begin
              tail_root <= fres;
              state     <= ST_ALLOC_TAKE;
            end
            CL_SCAN: begin
              mem_we    <= 1'b1;
              mem_waddr <= to_base + AW'(scan_ptr);
              mem_wdata <= {scan_word[WW-1 -: 1+AW], fres, scan_word[VALUE_BITS-1:0]};
              scan_ptr  <= scan_ptr + SW'(1);
              page_cnt  <= page_cnt - PW'(1);
              state     <= ST_SCAN;
            end
            default: state <= ST_DONE;
          endcase
        end
        ST_ACC_W: state <= ST_ACC_DO;
        ST_ACC_DO: begin
          case (mode_r)
            icgc_pkg::MODE_RD_VALUE: res_value <= rd_val;
            icgc_pkg::MODE_RD_LINK:  res_ptr   <= rd_link;
            icgc_pkg::MODE_WR_VALUE: begin
              mem_we    <= 1'b1;
              mem_waddr <= res_handle[AW-1:0];
              mem_wdata <= {mem_rdata[WW-1:VALUE_BITS], wval_r};
            end
            icgc_pkg::MODE_WR_LINK: begin
              mem_we    <= 1'b1;
              mem_waddr <= res_handle[AW-1:0];
              mem_wdata <= {mem_rdata[WW-1 -: 1+AW], wptr_norm, rd_val};
            end
            default: ;
          endcase
          state <= ST_DONE;
        end
        ST_SCAN: begin
          if (page_cnt != '0 && scan_ptr < free_ptr) begin
            mem_re    <= 1'b1;
            mem_raddr <= to_base + AW'(scan_ptr);
            state     <= ST_SCAN_W;
          end else if (scan_ptr >= free_ptr) begin
            // collection done: sweep the whole from-space
            collecting <= 1'b0;
            clr_boot   <= 1'b0;
            clr_addr   <= from_base;
            clr_last   <= from_base + AW'(SPACE_OBJS - 1);
            state      <= ST_CLEAR;
          end else begin
            state <= ST_ALLOC_FLIP;
          end
        end
        ST_SCAN_W: state <= ST_SCAN_GOT;
        ST_SCAN_GOT: begin
          scan_word <= mem_rdata;
          fh        <= rd_link;
          caller    <= CL_SCAN;
          state     <= ST_FWD;
        end
        ST_ALLOC_FLIP: begin
          if (slot_full && !collecting) begin
            to_half    <= ~to_half;
            free_ptr   <= '0;
            scan_ptr   <= '0;
            collecting <= 1'b1;
            fh         <= head_root;
            caller     <= CL_FLIP1;
            state      <= ST_FWD;
          end else begin
            state <= ST_ALLOC_TAKE;
          end
        end
        ST_ALLOC_TAKE: begin
          if (slot_full) begin
            oos <= 1'b1;
          end else begin
            mem_we     <= 1'b1;
            mem_waddr  <= new_slot;
            mem_wdata  <= clear_word;
            res_handle <= {1'b0, new_slot};
            free_ptr   <= free_ptr + SW'(1);
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (res_free) begin
            if (status_r == icgc_pkg::STATUS_OK && oos) begin
              status_r <= icgc_pkg::STATUS_OOS;
            end
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_free_in_space: assert property (@(posedge clk) disable iff (rst)
    free_ptr < SW'(SPACE_OBJS - 1) || free_ptr == SW'(SPACE_OBJS - 1))
    else $error("free pointer beyond to-space");

  a_scan_behind_free: assert property (@(posedge clk) disable iff (rst)
    scan_ptr <= free_ptr)
    else $error("scan pointer passed free pointer");

  a_null_status: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status == icgc_pkg::STATUS_NULL) |-> res_handle == NULL_H)
    else $error("null access returned a handle");

  a_flip_starts_collect: assert property (@(posedge clk) disable iff (rst)
    (to_half != $past(to_half)) |-> collecting && free_ptr == '0)
    else $error("flip without collection start");

endmodule

[hw/rtl/incremental_copying_gc.sv]
// channel  | dir | tdata (low bit up)                    | tuser
// s_axis   | in  | handle, write_value, write_ptr, zeros | mode, root_select
// m_axis   | out | handle_out, read_value, read_ptr, zeros| status
//
// a plain access makes up to two reads and three writes through the memory's
// read and write ports. an alloc scans up to PAGE_OBJS objects, may flip the
// spaces and, when a collection ends, sweeps the SPACE_OBJS words of the
// from-space. after reset all 2*SPACE_OBJS words of the memory are swept
// with s_axis_tready low. one item at a time; a waiting result holds the next.
module incremental_copying_gc #(
  parameter int unsigned SPACE_OBJS = icgc_pkg::SPACE_OBJS_DEF,
  parameter int unsigned PAGE_OBJS  = icgc_pkg::PAGE_OBJS_DEF,
  parameter int unsigned VALUE_BITS = icgc_pkg::VALUE_BITS_DEF,
  localparam int unsigned HW     = $clog2(2 * SPACE_OBJS) + 1,
  localparam int unsigned D_BITS = HW + VALUE_BITS + HW,
  localparam int unsigned D_W    = ((D_BITS + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [D_W-1:0]                   s_axis_tdata,  // handle, write_value, write_ptr
  input  logic [icgc_pkg::MODE_BITS:0]     s_axis_tuser,  // mode, root_select
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [D_W-1:0]                   m_axis_tdata,  // handle_out, read_value, read_ptr
  output logic [icgc_pkg::STATUS_BITS-1:0] m_axis_tuser   // status
);

  localparam int unsigned NOBJ = 2 * SPACE_OBJS;
  localparam int unsigned AW   = $clog2(NOBJ);
  localparam int unsigned WW   = 1 + AW + HW + VALUE_BITS;

  logic                             res_valid;
  logic [HW-1:0]                    res_handle;
  logic [VALUE_BITS-1:0]            res_value;
  logic [HW-1:0]                    res_ptr;
  logic [icgc_pkg::STATUS_BITS-1:0] res_status;
  logic                             res_free;
  logic                             mem_we;
  logic [AW-1:0]                    mem_waddr;
  logic [WW-1:0]                    mem_wdata;
  logic                             mem_re;
  logic [AW-1:0]                    mem_raddr;
  logic [WW-1:0]                    mem_rdata;

  assign res_free = !m_axis_tvalid || m_axis_tready;

  icgc_engine #(
    .SPACE_OBJS (SPACE_OBJS),
    .PAGE_OBJS  (PAGE_OBJS),
    .VALUE_BITS (VALUE_BITS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_mode    (s_axis_tuser[icgc_pkg::MODE_BITS-1:0]),
    .in_handle  (s_axis_tdata[HW-1:0]),
    .in_sel     (s_axis_tuser[icgc_pkg::MODE_BITS]),
    .in_wval    (s_axis_tdata[HW +: VALUE_BITS]),
    .in_wptr    (s_axis_tdata[HW+VALUE_BITS +: HW]),
    .res_free   (res_free),
    .res_valid  (res_valid),
    .res_handle (res_handle),
    .res_value  (res_value),
    .res_ptr    (res_ptr),
    .res_status (res_status),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  icgc_store #(
    .DEPTH (NOBJ),
    .WIDTH (WW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register decouples the result from the next item
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_axis_tdata <= D_W'({res_ptr, res_value, res_handle});
      m_axis_tuser <= res_status;
    end
  end

endmodule

[tb/sv/incremental_copying_gc_tb.sv]
`timescale 1ns / 100ps

module incremental_copying_gc_tb;

  localparam int unsigned NOBJ = 2 * icgc_pkg::SPACE_OBJS_DEF;
  localparam int unsigned HALF = icgc_pkg::SPACE_OBJS_DEF;
  localparam int unsigned PAGE = icgc_pkg::PAGE_OBJS_DEF;
  localparam logic [9:0] NULL_H = 10'd512;
  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam int D_W = 56;

  typedef struct packed {
    logic [2:0]  mode;
    logic [9:0]  handle;
    logic        root_sel;
    logic [31:0] wr_value;
    logic [9:0]  wr_ptr;
  } access_t;

  typedef struct packed {
    logic [9:0]  handle_out;
    logic [31:0] rd_value;
    logic [9:0]  rd_ptr;
    logic [1:0]  status;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [D_W-1:0] s_axis_tdata = '0;
  logic [3:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [D_W-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  incremental_copying_gc uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #10 clk = ~clk;

  // collector state mirror
  logic [31:0] heap_value [NOBJ];
  logic [9:0]  heap_link [NOBJ];
  logic        fwd_marked [NOBJ];
  logic [9:0]  fwd_target [NOBJ];
  logic        defined [NOBJ];
  logic        upper_is_to;
  int unsigned free_slot, scan_slot;
  logic        collecting, space_short;
  logic [9:0]  head_root, tail_root;

  access_t pending_accesses[$];
  answer_t expected_answers[$];
  int send_idle_pct = 0, recv_stall_pct = 0;
  int hold_requests = 0, hold_served = 0, hold_left = 0;
  int errors = 0;

  function automatic int unsigned to_base();
    return upper_is_to ? HALF : 0;
  endfunction

  function automatic logic in_from_space(logic [9:0] h);
    if (h >= NULL_H) return 1'b0;
    return (h >= HALF) != upper_is_to;
  endfunction

  function automatic logic [9:0] take_slot();
    logic [9:0] n;
    if (free_slot + 1 >= HALF) begin
      space_short = 1'b1;
      return NULL_H;
    end
    n = 10'(to_base() + free_slot);
    free_slot++;
    return n;
  endfunction

  function automatic logic [9:0] forward(logic [9:0] h);
    logic [9:0] n;
    if (!in_from_space(h)) return h;
    if (fwd_marked[h]) return fwd_target[h];
    n = take_slot();
    if (n == NULL_H) return h;
    heap_value[n] = heap_value[h];
    heap_link[n] = heap_link[h];
    defined[n] = 1'b1;
    fwd_marked[n] = 1'b0;
    fwd_marked[h] = 1'b1;
    fwd_target[h] = n;
    return n;
  endfunction

  function automatic logic [9:0] allocate();
    int unsigned stop, base;
    logic [9:0] n;
    if (collecting && scan_slot < free_slot) begin
      stop = scan_slot + PAGE;
      while (scan_slot < stop && scan_slot < free_slot && scan_slot < HALF) begin
        n = 10'(to_base() + scan_slot);
        heap_link[n] = forward(heap_link[n]);
        scan_slot++;
      end
      if (scan_slot >= free_slot) begin
        base = upper_is_to ? 0 : HALF;
        for (int i = 0; i < HALF; i++) begin
          heap_value[base + i] = '0;
          heap_link[base + i] = NULL_H;
          fwd_marked[base + i] = 1'b0;
          defined[base + i] = 1'b1;
        end
        collecting = 1'b0;
      end
    end
    if (free_slot + 1 >= HALF && !collecting) begin
      upper_is_to = ~upper_is_to;
      free_slot = 0;
      scan_slot = 0;
      collecting = 1'b1;
      head_root = forward(head_root);
      tail_root = forward(tail_root);
    end
    n = take_slot();
    if (n != NULL_H) begin
      heap_value[n] = '0;
      heap_link[n] = NULL_H;
      fwd_marked[n] = 1'b0;
      defined[n] = 1'b1;
    end
    return n;
  endfunction

  function automatic answer_t predict_access(access_t a);
    answer_t r;
    logic [9:0] h, wp;
    r = '{handle_out: NULL_H, rd_value: '0, rd_ptr: NULL_H, status: icgc_pkg::STATUS_OK};
    wp = (a.wr_ptr >= NULL_H) ? NULL_H : a.wr_ptr;
    space_short = 1'b0;
    case (a.mode)
      icgc_pkg::MODE_ALLOC: r.handle_out = allocate();
      icgc_pkg::MODE_RD_VALUE, icgc_pkg::MODE_WR_VALUE, icgc_pkg::MODE_RD_LINK,
      icgc_pkg::MODE_WR_LINK: begin
        if (a.handle >= NULL_H) begin
          r.status = icgc_pkg::STATUS_NULL;
        end else begin
          h = forward(a.handle);
          r.handle_out = h;
          case (a.mode)
            icgc_pkg::MODE_RD_VALUE: r.rd_value = heap_value[h];
            icgc_pkg::MODE_WR_VALUE: heap_value[h] = a.wr_value;
            icgc_pkg::MODE_RD_LINK: r.rd_ptr = heap_link[h];
            default: heap_link[h] = wp;
          endcase
        end
      end
      icgc_pkg::MODE_RD_ROOT: begin
        if (a.root_sel) begin
          tail_root = forward(tail_root);
          r.rd_ptr = tail_root;
        end else begin
          head_root = forward(head_root);
          r.rd_ptr = head_root;
        end
      end
      icgc_pkg::MODE_WR_ROOT: begin
        if (a.root_sel) tail_root = wp;
        else head_root = wp;
      end
      default: ;
    endcase
    if (r.status == icgc_pkg::STATUS_OK && space_short) r.status = icgc_pkg::STATUS_OOS;
    return r;
  endfunction

  task automatic issue(logic [2:0] m, logic [9:0] h, logic sel, logic [31:0] v,
                       logic [9:0] p);
    access_t a;
    a = '{mode: m, handle: h, root_sel: sel, wr_value: v, wr_ptr: p};
    pending_accesses.push_back(a);
    expected_answers.push_back(predict_access(a));
  endtask

  // only objects that hold defined contents may be touched
  function automatic logic [9:0] live_handle();
    logic [9:0] h;
    repeat (24) begin
      h = 10'($urandom_range(0, NOBJ - 1));
      if (defined[h]) return h;
    end
    return NULL_H;
  endfunction

  function automatic logic [9:0] random_ptr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return live_handle();
    if (r < 85) return NULL_H;
    return 10'($urandom_range(513, 1023));
  endfunction

  task automatic random_access();
    int r;
    logic [9:0] h;
    r = $urandom_range(0, 99);
    h = ($urandom_range(0, 99) < 6) ? 10'($urandom_range(512, 1023)) : live_handle();
    if (r < 38) issue(icgc_pkg::MODE_ALLOC, 10'($urandom), 1'($urandom), $urandom,
                      10'($urandom));
    else if (r < 50) issue(icgc_pkg::MODE_RD_VALUE, h, 1'($urandom), $urandom, random_ptr());
    else if (r < 62) issue(icgc_pkg::MODE_WR_VALUE, h, 1'($urandom), $urandom, random_ptr());
    else if (r < 72) issue(icgc_pkg::MODE_RD_LINK, h, 1'($urandom), $urandom, random_ptr());
    else if (r < 85) issue(icgc_pkg::MODE_WR_LINK, h, 1'($urandom), $urandom, random_ptr());
    else if (r < 92) issue(icgc_pkg::MODE_RD_ROOT, h, 1'($urandom), $urandom, random_ptr());
    else if (r < 99) issue(icgc_pkg::MODE_WR_ROOT, h, 1'($urandom), $urandom, random_ptr());
    else issue(MODE_UNUSED, h, 1'($urandom), $urandom, random_ptr());
  endtask

  task automatic drain();
    while (pending_accesses.size() != 0 || expected_answers.size() != 0)
      @(posedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) void'(pending_accesses.pop_front());
      if (pending_accesses.size() != 0 && ($urandom_range(0, 99) >= send_idle_pct ||
          (s_axis_tvalid && !s_axis_tready))) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, pending_accesses[0].wr_ptr, pending_accesses[0].wr_value,
                         pending_accesses[0].handle};
        s_axis_tuser <= {pending_accesses[0].root_sel, pending_accesses[0].mode};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left <= 400;
    end
  end

  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= (hold_left <= 1) && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    answer_t exp_a, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{handle_out: m_axis_tdata[9:0], rd_value: m_axis_tdata[41:10],
              rd_ptr: m_axis_tdata[51:42], status: m_axis_tuser};
      if (expected_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected item %h", $time, got);
      end else begin
        exp_a = expected_answers.pop_front();
        if (got.handle_out !== exp_a.handle_out)
          $display("%0t: handle_out expected %0d got %0d", $time, exp_a.handle_out,
                   got.handle_out);
        if (got.rd_value !== exp_a.rd_value)
          $display("%0t: read_value expected %h got %h", $time, exp_a.rd_value, got.rd_value);
        if (got.rd_ptr !== exp_a.rd_ptr)
          $display("%0t: read_ptr expected %0d got %0d", $time, exp_a.rd_ptr, got.rd_ptr);
        if (got.status !== exp_a.status)
          $display("%0t: status expected %0d got %0d", $time, exp_a.status, got.status);
        if (got !== exp_a) errors++;
      end
    end
  end

  initial begin
    #200_000_000;
    $display("incremental_copying_gc_tb: errors");
    $finish;
  end

  initial begin
    logic [9:0] a0, a1;
    for (int i = 0; i < NOBJ; i++) begin
      fwd_marked[i] = 1'b0;
      defined[i] = 1'b0;
      heap_value[i] = '0;
      heap_link[i] = NULL_H;
      fwd_target[i] = '0;
    end
    upper_is_to = 1'b1;
    free_slot = 0;
    scan_slot = 0;
    collecting = 1'b0;
    head_root = NULL_H;
    tail_root = NULL_H;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every mode, null and oversize handles and pointers
    issue(icgc_pkg::MODE_RD_ROOT, 0, 1'b0, 0, 0);
    issue(icgc_pkg::MODE_RD_ROOT, 0, 1'b1, 0, 0);
    issue(icgc_pkg::MODE_ALLOC, 10'h3FF, 1'b1, 32'hFFFFFFFF, 10'h3FF);
    a0 = expected_answers[$].handle_out;
    issue(icgc_pkg::MODE_ALLOC, 0, 0, 0, 0);
    a1 = expected_answers[$].handle_out;
    issue(icgc_pkg::MODE_WR_VALUE, a0, 0, 32'h80000000, 0);
    issue(icgc_pkg::MODE_RD_VALUE, a0, 0, 0, 0);
    issue(icgc_pkg::MODE_WR_VALUE, a1, 0, 32'h7FFFFFFF, 0);
    issue(icgc_pkg::MODE_RD_VALUE, a1, 0, 0, 0);
    issue(icgc_pkg::MODE_WR_VALUE, a1, 0, 32'hFFFFFFFF, 0);
    issue(icgc_pkg::MODE_WR_LINK, a0, 0, 0, a1);
    issue(icgc_pkg::MODE_RD_LINK, a0, 0, 0, 0);
    issue(icgc_pkg::MODE_WR_LINK, a1, 0, 0, 10'h3FF);
    issue(icgc_pkg::MODE_RD_LINK, a1, 0, 0, 0);
    issue(icgc_pkg::MODE_WR_ROOT, 0, 1'b0, 0, a0);
    issue(icgc_pkg::MODE_WR_ROOT, 0, 1'b1, 0, a1);
    issue(icgc_pkg::MODE_RD_ROOT, 0, 1'b0, 0, 0);
    issue(icgc_pkg::MODE_RD_ROOT, 0, 1'b1, 0, 0);
    issue(icgc_pkg::MODE_RD_VALUE, NULL_H, 0, 0, 0);
    issue(icgc_pkg::MODE_WR_LINK, 10'h3FF, 0, 0, 0);
    issue(icgc_pkg::MODE_RD_LINK, NULL_H, 0, 0, 0);
    issue(icgc_pkg::MODE_WR_VALUE, 10'h3FF, 1, 32'h12345678, 0);
    issue(MODE_UNUSED, a0, 1, 32'hFFFFFFFF, 10'h3FF);
    issue(icgc_pkg::MODE_RD_VALUE, a1, 0, 0, 0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 45; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 45; hold_requests++; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      repeat (335) random_access();
      drain();
    end

    repeat (1200) @(posedge clk);
    if (errors == 0 && expected_answers.size() == 0)
      $display("incremental_copying_gc_tb: clean");
    else
      $display("incremental_copying_gc_tb: errors");
    $finish;
  end

endmodule

[files.f]
hw/rtl/icgc_pkg.sv
hw/rtl/icgc_store.sv
hw/rtl/icgc_engine.sv
hw/rtl/incremental_copying_gc.sv
tb/sv/incremental_copying_gc_tb.sv
